FILE: rtl/rasp_pkg.sv
// Shared types and operation codes for the return address stack predictor.
`timescale 1ns / 1ps
`default_nettype none

package rasp_pkg;

    localparam int ADDR_W = 32;
    localparam int OP_W   = 2;
    localparam int CNT_W  = 32;

    // Operation codes carried on the input tuser
    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_POP     = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESOLVE = 2'd3;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Stack update commands for one transfer
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_ctrl_t;

    // Counter update commands for one transfer
    typedef struct packed {
        logic resolve;
        logic miss;
    } ctr_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/return_address_stack_predictor.sv
// Top level: input register, stack and counter update, result register.
// Each item is held first in the input register and then in the result register,
// from which its result is transferred.
// Throughput: one item per cycle unless the result side stalls; the stack and counters
// update in the cycle the item moves from the input register to the result register.
// Reset (rst_n low, asynchronous) clears the stack to zeros, both counters
// and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module return_address_stack_predictor
    import rasp_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [95:0]  s_axis_tdata,   // push_addr, actual_target, predicted_target
    input  wire  [1:0]   s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [103:0] m_axis_tdata    // popped_addr, mispredict, flush_pipeline,
                                         // prediction_total, mispredict_total, zero pad
);

    // Input register
    logic            in_valid_reg;
    logic [OP_W-1:0] in_op_reg;
    addr_t           in_push_reg;
    addr_t           in_actual_reg;
    addr_t           in_pred_reg;

    // Result register
    logic  out_valid_reg;
    addr_t out_popped_reg;
    logic  out_miss_reg;
    cnt_t  out_resolved_reg;
    cnt_t  out_missed_reg;

    logic        advance;
    logic        miss;
    stack_ctrl_t stack_ctrl;
    ctr_ctrl_t   ctr_ctrl;
    addr_t       stack_top;
    cnt_t        resolved_next;
    cnt_t        missed_next;

    // Handshake: item moves on when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg     <= s_axis_tuser;
            in_push_reg   <= s_axis_tdata[31:0];
            in_actual_reg <= s_axis_tdata[63:32];
            in_pred_reg   <= s_axis_tdata[95:64];
        end
    end

    // Decode the operation
    assign miss = (in_op_reg == OP_RESOLVE) && (in_actual_reg != in_pred_reg);

    always_comb
    begin
        stack_ctrl = '0;
        ctr_ctrl   = '0;
        if (advance)
        begin
            unique case (in_op_reg)
                OP_PUSH:    stack_ctrl.push  = 1'b1;
                OP_POP:     stack_ctrl.pop   = 1'b1;
                OP_FLUSH:   stack_ctrl.clear = 1'b1;
                OP_RESOLVE:
                begin
                    ctr_ctrl.resolve = 1'b1;
                    ctr_ctrl.miss    = miss;
                    stack_ctrl.clear = miss;
                end
                default:    stack_ctrl = '0;
            endcase
        end
    end

    rasp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (stack_ctrl),
        .push_addr (in_push_reg),
        .top       (stack_top)
    );

    rasp_ctr u_ctr (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctr_ctrl),
        .resolved_next (resolved_next),
        .missed_next   (missed_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_popped_reg   <= (in_op_reg == OP_POP) ? stack_top : '0;
            out_miss_reg     <= miss;
            out_resolved_reg <= resolved_next;
            out_missed_reg   <= missed_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_missed_reg, out_resolved_reg,
                            out_miss_reg, out_miss_reg, out_popped_reg};

endmodule

`default_nettype wire

FILE: rtl/rasp_stack.sv
// Shift-register return address stack; the top is the highest entry.
`timescale 1ns / 1ps
`default_nettype none

module rasp_stack
    import rasp_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  stack_ctrl_t ctrl,
    input  addr_t       push_addr,
    output addr_t       top
);

    addr_t entries_reg  [STACK_DEPTH];
    addr_t entries_next [STACK_DEPTH];

    assign top = entries_reg[STACK_DEPTH-1];

    // All entries shift in parallel on push and pop
    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        if (ctrl.clear)
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                entries_next[i] = '0;
            end
        end
        else if (ctrl.push)
        begin
            for (int i = 0; i < STACK_DEPTH - 1; i++)
            begin
                entries_next[i] = entries_reg[i+1];
            end
            entries_next[STACK_DEPTH-1] = push_addr;
        end
        else if (ctrl.pop)
        begin
            for (int i = STACK_DEPTH - 1; i > 0; i--)
            begin
                entries_next[i] = entries_reg[i-1];
            end
            entries_next[0] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rasp_ctr.sv
// Wrapping prediction and mispredict counters.
`timescale 1ns / 1ps
`default_nettype none

module rasp_ctr
    import rasp_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  ctr_ctrl_t ctrl,
    output cnt_t      resolved_next,
    output cnt_t      missed_next
);

    cnt_t resolved_reg;
    cnt_t missed_reg;

    // Values after this transfer, also fed to the result register
    assign resolved_next = ctrl.resolve ? resolved_reg + 1'b1 : resolved_reg;
    assign missed_next   = ctrl.miss    ? missed_reg + 1'b1   : missed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolved_reg <= '0;
            missed_reg   <= '0;
        end
        else
        begin
            resolved_reg <= resolved_next;
            missed_reg   <= missed_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rasp_checker.sv
// Port-level checks for the return address stack predictor, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module rasp_checker
    import rasp_pkg::*;
(
    input wire         clk,
    input wire         rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [1:0]   s_axis_tuser,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [103:0] m_axis_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Mispredict and pipeline flush always travel together
    a_miss_flush: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[32] == m_axis_tdata[33])
        else $error("mispredict and flush_pipeline differ");

    // A mispredict result never carries a popped address
    a_miss_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("popped address on a mispredict result");

    // Input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with no result waiting");

    // A non-resolve item, once it reaches the result register, shows no mispredict
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_RESOLVE)
        ##1 (m_axis_tready || !m_axis_tvalid)
        |=> m_axis_tvalid && !m_axis_tdata[32])
        else $error("mispredict reported for a non-resolve item");

endmodule

bind return_address_stack_predictor rasp_checker u_rasp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: sim/return_address_stack_predictor_tb.sv
// Testbench for the return address stack predictor: directed and random streams against a predictor.
`timescale 1ns / 1ps

module return_address_stack_predictor_tb;

    import rasp_pkg::*;

    localparam int STACK_DEPTH    = 8;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    // One expected result, unpacked
    typedef struct {
        addr_t popped;
        logic  miss;
        logic  flush;
        cnt_t  pred_total;
        cnt_t  miss_total;
    } ras_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;   // push_addr, actual_target, predicted_target
    logic [1:0]   s_axis_tuser;   // op
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // popped_addr, mispredict, flush_pipeline,
                                  // prediction_total, mispredict_total, zero pad

    // Predictor state
    addr_t       ras_model [STACK_DEPTH];
    cnt_t        resolved_cnt;
    cnt_t        missed_cnt;
    ras_result_t expected_q [$];

    int errors       = 0;
    int items_sent   = 0;
    int idle_cycles  = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    int rx_hold_req  = 0;

    return_address_stack_predictor #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Clock, 12 ns period
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Apply one operation to the predicted stack and counters
    function automatic void predict_step(logic [1:0] op, addr_t push_addr,
                                         addr_t actual, addr_t predicted);
        ras_result_t r;
        r.popped = '0;
        r.miss   = 1'b0;
        r.flush  = 1'b0;
        case (op)
            OP_PUSH:
            begin
                for (int i = 0; i < STACK_DEPTH - 1; i++)
                    ras_model[i] = ras_model[i + 1];
                ras_model[STACK_DEPTH - 1] = push_addr;
            end
            OP_POP:
            begin
                r.popped = ras_model[STACK_DEPTH - 1];
                for (int i = STACK_DEPTH - 1; i > 0; i--)
                    ras_model[i] = ras_model[i - 1];
                ras_model[0] = '0;
            end
            OP_FLUSH:
            begin
                for (int i = 0; i < STACK_DEPTH; i++)
                    ras_model[i] = '0;
            end
            OP_RESOLVE:
            begin
                resolved_cnt = resolved_cnt + 1;
                if (actual != predicted)
                begin
                    missed_cnt = missed_cnt + 1;
                    r.miss     = 1'b1;
                    r.flush    = 1'b1;
                    for (int i = 0; i < STACK_DEPTH; i++)
                        ras_model[i] = '0;
                end
            end
        endcase
        r.pred_total = resolved_cnt;
        r.miss_total = missed_cnt;
        expected_q.push_back(r);
    endfunction

    // Offer one item, wait for the transfer, then idle a random gap (none in steady mode)
    task automatic send_op(input logic [1:0] op, input addr_t push_addr,
                           input addr_t actual, input addr_t predicted);
        int gap;
        s_axis_tuser  = op;
        s_axis_tdata  = {predicted, actual, push_addr};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_step(op, push_addr, actual, predicted);
        items_sent++;
        @(negedge clk);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Sender pauses until every expected result is back
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Empty pop, overfill by one, then pop everything back out
    task automatic test_stack_extremes();
        send_op(OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_op(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_op(OP_PUSH, 32'h0, 32'h0, 32'hFFFF_FFFF);
        for (int i = 1; i <= STACK_DEPTH - 1; i++)
            send_op(OP_PUSH, 32'h1111_1111 * i, $urandom, $urandom);
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_op(OP_POP, $urandom, $urandom, $urandom);
    endtask

    // Flush clears the stack
    task automatic test_flush();
        send_op(OP_PUSH, 32'hA5A5_5A5A, 32'h0, 32'h0);
        send_op(OP_FLUSH, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321);
        send_op(OP_POP, 32'h0, 32'h0, 32'h0);
    endtask

    // Hit keeps the stack, miss clears it and raises the flags
    task automatic test_resolve();
        send_op(OP_PUSH, 32'h8000_0004, 32'h0, 32'h0);
        send_op(OP_RESOLVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_RESOLVE, 32'h0, 32'h0, 32'h0);
        send_op(OP_RESOLVE, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_op(OP_POP, 32'h0, 32'h0, 32'h0);
    endtask

    // Receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        tx_steady   = 1'b1;
        rx_hold_req = 200;
        @(negedge clk);
        for (int i = 0; i < 24; i++)
            send_op(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        tx_steady = 1'b0;
        drain_results();
    endtask

    // Call and return sequences with random content, plus noise
    task automatic test_random_stream();
        int    r;
        addr_t top;
        addr_t actual;
        while (items_sent < RANDOM_ITEMS)
        begin
            // Change idling mode every so often
            if ((items_sent % 150) < 2)
            begin
                tx_steady = ($urandom_range(0, 4) == 0);
                rx_steady = ($urandom_range(0, 4) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                send_op(OP_PUSH, $urandom, $urandom, $urandom);
            end
            else if (r < 75)
            begin
                // Return: pop the prediction, then resolve against it
                top = ras_model[STACK_DEPTH - 1];
                send_op(OP_POP, $urandom, $urandom, $urandom);
                actual = ($urandom_range(0, 99) < 85) ? top : addr_t'($urandom);
                send_op(OP_RESOLVE, $urandom, actual, top);
            end
            else if (r < 82)
            begin
                // Deep calls: a run of pushes that can fill past the top
                for (int i = 0; i < $urandom_range(4, 12); i++)
                    send_op(OP_PUSH, $urandom, $urandom, $urandom);
            end
            else if (r < 90)
            begin
                send_op(OP_RESOLVE, $urandom, $urandom, $urandom);
            end
            else if (r < 95)
            begin
                send_op(OP_FLUSH, $urandom, $urandom, $urandom);
            end
            else
            begin
                send_op(OP_POP, $urandom, $urandom, $urandom);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Result side ready: random runs and stalls, steady mode, long hold-off
    initial
    begin : rx_ready_gen
        int run_left;
        int stall_left;
        int hold_left;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else if (rx_steady)
            begin
                m_axis_tready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left   = $urandom_range(1, 24);
                    stall_left = pick_gap();
                end
                m_axis_tready = 1'b1;
                run_left--;
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        ras_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with none expected, actual tdata %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tdata[31:0] !== want.popped)
                begin
                    $display("%0t: popped_addr expected %h actual %h",
                             $time, want.popped, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[32] !== want.miss)
                begin
                    $display("%0t: mispredict expected %b actual %b",
                             $time, want.miss, m_axis_tdata[32]);
                    errors++;
                end
                if (m_axis_tdata[33] !== want.flush)
                begin
                    $display("%0t: flush_pipeline expected %b actual %b",
                             $time, want.flush, m_axis_tdata[33]);
                    errors++;
                end
                if (m_axis_tdata[65:34] !== want.pred_total)
                begin
                    $display("%0t: prediction_total expected %h actual %h",
                             $time, want.pred_total, m_axis_tdata[65:34]);
                    errors++;
                end
                if (m_axis_tdata[97:66] !== want.miss_total)
                begin
                    $display("%0t: mispredict_total expected %h actual %h",
                             $time, want.miss_total, m_axis_tdata[97:66]);
                    errors++;
                end
                if (m_axis_tdata[103:98] !== 6'd0)
                begin
                    $display("%0t: pad expected %h actual %h",
                             $time, 6'd0, m_axis_tdata[103:98]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** return_address_stack_predictor: FAILED **");
            $finish;
        end
    end

    // Reset, then the tests in turn
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUSH;
        for (int i = 0; i < STACK_DEPTH; i++)
            ras_model[i] = '0;
        resolved_cnt = '0;
        missed_cnt   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_stack_extremes();
        test_flush();
        test_resolve();
        drain_results();
        test_backpressure();
        items_sent = 0;
        test_random_stream();
        drain_results();

        if (errors == 0 && expected_q.size() == 0)
            $display("** return_address_stack_predictor: PASSED **");
        else
            $display("** return_address_stack_predictor: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/rasp_pkg.sv
rtl/rasp_stack.sv
rtl/rasp_ctr.sv
rtl/return_address_stack_predictor.sv
rtl/rasp_checker.sv
sim/return_address_stack_predictor_tb.sv
